// ===== rtl/pcvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvc_pkg
// Shared types and constants of the pair compare hub vote classifier.
// ----------------------------------------------------------------------------
package pcvc_pkg;

  // Pair weight is unsigned Q8.8; per-hub weight sums are Q16.8.
  localparam int PAIR_W     = 16;
  localparam int WEIGHT_W   = 24;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

  // Result transfer carries the hub vote in one padded byte of tdata.
  localparam int OUT_DATA_W = 8;

  // Per-item control flags.
  typedef struct packed {
    logic less_than;
    logic last_neighbor;
    logic last_hub;
  } pcvc_flags_t;

  // One result item.
  typedef struct packed {
    logic hub_vote;
    logic sample_done;
    logic sample_class;
  } pcvc_result_t;

endpackage

// ===== rtl/pcvc_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvc_in_stage
// Input register: captures one pair per transfer and holds it until the
// accumulate stage takes it.
// ----------------------------------------------------------------------------
module pcvc_in_stage
  import pcvc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int DATA_W      = 80
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [DATA_W-1:0]             s_axis_tdata,
  input  logic                          s_axis_tlast,
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          advance,
  output logic                          item_valid,
  output logic signed [VALUE_WIDTH-1:0] center_value,
  output logic signed [VALUE_WIDTH-1:0] neighbor_value,
  output logic [PAIR_W-1:0]             pair_weight,
  output pcvc_flags_t                   flags
);

  // The register can take a new transfer when empty or when drained now.
  assign s_axis_tready = !item_valid || advance;

  // Valid bit of the held item.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  // Payload capture; no reset needed.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      center_value        <= s_axis_tdata[VALUE_WIDTH-1:0];
      neighbor_value      <= s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
      pair_weight         <= s_axis_tdata[2*VALUE_WIDTH+PAIR_W-1:2*VALUE_WIDTH];
      flags.less_than     <= s_axis_tuser[0];
      flags.last_neighbor <= s_axis_tlast;
      flags.last_hub      <= s_axis_tuser[1];
    end
  end

endmodule

// ===== rtl/pcvc_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvc_accum
// Pair compare, saturating per-hub and per-sample accumulation, and the hub
// and sample decisions for the item that leaves the input register.
// ----------------------------------------------------------------------------
module pcvc_accum
  import pcvc_pkg::*;
#(
  parameter int VALUE_WIDTH   = 32,
  parameter int MAX_NEIGHBORS = 256,
  parameter int MAX_HUBS      = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          agg_mode,
  input  logic signed [VALUE_WIDTH-1:0] center_value,
  input  logic signed [VALUE_WIDTH-1:0] neighbor_value,
  input  logic [PAIR_W-1:0]             pair_weight,
  input  pcvc_flags_t                   flags,
  output pcvc_result_t                  result
);

  localparam int NW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int NW1 = NW + 1;
  localparam int HW  = $clog2(MAX_HUBS + 1);
  localparam int HW1 = HW + 1;
  localparam logic [NW:0] N_LIMIT = NW1'(MAX_NEIGHBORS);
  localparam logic [HW:0] H_LIMIT = HW1'(MAX_HUBS);

  logic [NW-1:0]       yes_count, yes_count_next;
  logic [NW-1:0]       neighbor_count, neighbor_count_next;
  logic [WEIGHT_W-1:0] yes_weight, yes_weight_next;
  logic [WEIGHT_W-1:0] total_weight, total_weight_next;
  logic [HW-1:0]       hub_yes_count, hub_yes_count_next;
  logic [HW-1:0]       hub_count, hub_count_next;

  logic          pair_yes;
  logic          vote;
  logic [NW:0]   n_inc, y_inc;
  logic [WEIGHT_W:0] tw_sum, yw_sum;
  logic [HW:0]   h_inc, hy_inc;

  // Pair vote; equal values never vote yes.
  assign pair_yes = flags.less_than ? (center_value < neighbor_value)
                                    : (center_value > neighbor_value);

  // Saturating per-hub counts and weight sums including this pair.
  always_comb begin
    n_inc  = {1'b0, neighbor_count} + NW1'(1);
    y_inc  = {1'b0, yes_count} + NW1'(1);
    tw_sum = {1'b0, total_weight} + {{(WEIGHT_W+1-PAIR_W){1'b0}}, pair_weight};
    yw_sum = {1'b0, yes_weight} + {{(WEIGHT_W+1-PAIR_W){1'b0}}, pair_weight};

    neighbor_count_next = (n_inc > N_LIMIT) ? N_LIMIT[NW-1:0] : n_inc[NW-1:0];
    total_weight_next   = tw_sum[WEIGHT_W] ? WEIGHT_MAX : tw_sum[WEIGHT_W-1:0];
    yes_count_next      = yes_count;
    yes_weight_next     = yes_weight;
    if (pair_yes) begin
      yes_count_next  = (y_inc > N_LIMIT) ? N_LIMIT[NW-1:0] : y_inc[NW-1:0];
      yes_weight_next = yw_sum[WEIGHT_W] ? WEIGHT_MAX : yw_sum[WEIGHT_W-1:0];
    end
  end

  // Hub decision on the updated weight sums (agg_mode) or counts.
  assign vote = agg_mode ? ({yes_weight_next, 1'b0} >= {1'b0, total_weight_next})
                         : ({yes_count_next, 1'b0} > {1'b0, neighbor_count_next});

  // Saturating per-sample hub counts including this hub.
  always_comb begin
    h_inc  = {1'b0, hub_count} + HW1'(1);
    hy_inc = {1'b0, hub_yes_count} + HW1'(1);
    hub_count_next     = (h_inc > H_LIMIT) ? H_LIMIT[HW-1:0] : h_inc[HW-1:0];
    hub_yes_count_next = hub_yes_count;
    if (vote) begin
      hub_yes_count_next = (hy_inc > H_LIMIT) ? H_LIMIT[HW-1:0] : hy_inc[HW-1:0];
    end
  end

  // Result for an item that ends a hub.
  always_comb begin
    result.hub_vote     = vote;
    result.sample_done  = flags.last_hub;
    result.sample_class = flags.last_hub &&
                          ({hub_yes_count_next, 1'b0} > {1'b0, hub_count_next});
  end

  // Accumulator state; cleared at hub end and sample end.
  always_ff @(posedge clk) begin
    if (rst) begin
      yes_count      <= '0;
      neighbor_count <= '0;
      yes_weight     <= '0;
      total_weight   <= '0;
      hub_yes_count  <= '0;
      hub_count      <= '0;
    end else if (advance) begin
      if (flags.last_neighbor) begin
        yes_count      <= '0;
        neighbor_count <= '0;
        yes_weight     <= '0;
        total_weight   <= '0;
        if (flags.last_hub) begin
          hub_yes_count <= '0;
          hub_count     <= '0;
        end else begin
          hub_yes_count <= hub_yes_count_next;
          hub_count     <= hub_count_next;
        end
      end else begin
        yes_count      <= yes_count_next;
        neighbor_count <= neighbor_count_next;
        yes_weight     <= yes_weight_next;
        total_weight   <= total_weight_next;
      end
    end
  end

endmodule

// ===== rtl/pcvc_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvc_out_reg
// Result register: holds one result until the downstream transfer completes.
// ----------------------------------------------------------------------------
module pcvc_out_reg
  import pcvc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  pcvc_result_t          result,
  output logic                  slot_free,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  output logic                  m_axis_tuser
);

  pcvc_result_t held;

  // A new result may enter when empty or when the current one leaves now.
  assign slot_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (slot_free) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot_free) begin
      held <= result;
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W-1){1'b0}}, held.hub_vote};
  assign m_axis_tlast = held.sample_done;
  assign m_axis_tuser = held.sample_class;

endmodule

// ===== rtl/pair_compare_vote_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_compare_vote_classifier_core
// Two-level hub vote classifier: pair compares vote per hub, hub votes vote
// per sample.
// Path: the pair that ends a hub is held in the input register, and its result
// then in the result register.
// Throughput: one pair per cycle; the input register drains while the result
// register waits, and stalls only when a hub-ending pair meets a full result.
// Reset: synchronous rst clears valid bits, all counters and agg_mode.
// ----------------------------------------------------------------------------
module pair_compare_vote_classifier_core
  import pcvc_pkg::*;
#(
  parameter int   MAX_NEIGHBORS = 256,
  parameter int   MAX_HUBS      = 64,
  parameter int   VALUE_WIDTH   = 32,
  localparam int  DATA_W        = ((2 * VALUE_WIDTH + PAIR_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,   // agg_mode
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: center_value, neighbor_value, pair_weight, zero pad
  input  logic [DATA_W-1:0]     s_axis_tdata,
  input  logic                  s_axis_tlast,  // last_neighbor
  // tuser: less_than, last_hub
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: hub_vote, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,  // sample_done
  output logic                  m_axis_tuser   // sample_class
);

  logic                          agg_mode;
  logic                          item_valid;
  logic                          advance;
  logic                          slot_free;
  logic                          load;
  logic signed [VALUE_WIDTH-1:0] center_value;
  logic signed [VALUE_WIDTH-1:0] neighbor_value;
  logic [PAIR_W-1:0]             pair_weight;
  pcvc_flags_t                   flags;
  pcvc_result_t                  result;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      agg_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      agg_mode <= cfg_wr_data;
    end
  end

  // Pairs without a result always move on; hub ends need a free result slot.
  assign advance = item_valid && (!flags.last_neighbor || slot_free);
  assign load    = advance && flags.last_neighbor;

  pcvc_in_stage #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DATA_W      (DATA_W)
  ) u_in_stage (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .s_axis_tuser   (s_axis_tuser),
    .advance        (advance),
    .item_valid     (item_valid),
    .center_value   (center_value),
    .neighbor_value (neighbor_value),
    .pair_weight    (pair_weight),
    .flags          (flags)
  );

  pcvc_accum #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .MAX_HUBS      (MAX_HUBS)
  ) u_accum (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .agg_mode       (agg_mode),
    .center_value   (center_value),
    .neighbor_value (neighbor_value),
    .pair_weight    (pair_weight),
    .flags          (flags),
    .result         (result)
  );

  pcvc_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .result        (result),
    .slot_free     (slot_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // The class bit is zero unless the result ends a sample.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser)
    else $error("sample_class set on a result that does not end the sample");

  // A held pair that cannot move on stays held.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid)
    else $error("input register lost a stalled pair");

  // A delivered result with nothing new behind it leaves the output empty.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !load |=> !m_axis_tvalid)
    else $error("result repeated after its transfer");

  // After reset no result is pending.
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !item_valid)
    else $error("valid state not cleared by reset");

endmodule
